// File: src/swlap_pkg.sv
package swlap_pkg;

  localparam int DIGIT_W   = 4;
  localparam int NUM_CELLS = 6;
  localparam int SEG_W     = 8;
  localparam int DEC_MOD   = 10;
  localparam int SEC_TENS  = 3;   // cell position of the seconds-tens digit
  localparam int SEXT_MOD  = 6;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    logic start_press;
    logic stop_press;
    logic lap_press;
    logic clear_press;
    logic show_lap;
  } in_req_t;

  typedef struct packed {
    logic [31:0] low_digit_segments;
    logic [15:0] high_digit_segments;
  } out_req_t;

  // Controls shared by every digit cell for one tick.
  typedef struct packed {
    logic adv;
    logic lap;
    logic clear;
    logic show;
  } cell_ctl_t;

  function automatic int cell_modulus(input int pos);
    return (pos == SEC_TENS) ? SEXT_MOD : DEC_MOD;
  endfunction

  function automatic logic [SEG_W-1:0] seg_of(input digit_t d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h3F;
    endcase
    return s;
  endfunction

endpackage

// File: src/swlap_digit_cell.sv
module swlap_digit_cell #(
  parameter int MODULUS = swlap_pkg::DEC_MOD
) (
  input  logic                clk,
  input  logic                rst_n,
  input  swlap_pkg::cell_ctl_t ctl,
  input  logic                carry_in,
  output logic                carry_out,
  output swlap_pkg::digit_t   shown
);

  localparam swlap_pkg::digit_t TOP = swlap_pkg::DIGIT_W'(MODULUS - 1);

  swlap_pkg::digit_t digit_r, digit_nxt;
  swlap_pkg::digit_t lap_r, lap_nxt;
  swlap_pkg::digit_t cur;

  always_comb begin
    // lap captures the count before clear takes effect
    lap_nxt   = ctl.lap ? digit_r : lap_r;
    cur       = ctl.clear ? '0 : digit_r;
    shown     = ctl.show ? lap_nxt : cur;
    carry_out = carry_in && (cur == TOP);
    if (carry_in) begin
      digit_nxt = (cur == TOP) ? '0 : cur + swlap_pkg::digit_t'(1);
    end else begin
      digit_nxt = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= '0;
      lap_r   <= '0;
    end else if (ctl.adv) begin
      digit_r <= digit_nxt;
      lap_r   <= lap_nxt;
    end
  end

endmodule

// File: src/stopwatch_lap_seven_segment_unit.sv
// Channel | Dir | Handshake           | Payload
// in_     | in  | in_valid / in_stall   | swlap_pkg::in_req_t  (buttons, lap-view switch)
// out_    | out | out_valid / out_stall | swlap_pkg::out_req_t (six segment bytes)
//
// One request per cycle is taken unless input is stalled; its display request
// appears in the next cycle from the output register. The live and lap counts
// sit in a row of six decimal digit cells (seconds tens counts modulo 6); the
// increment ripples as a carry. Synchronous active-low reset sets running and
// zeroes both counts. A stalled output holds its request; input is stalled only
// while the output register is full and stalled, so requests flow back to back otherwise.
module stopwatch_lap_seven_segment_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  swlap_pkg::in_req_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output swlap_pkg::out_req_t out_data
);

  localparam int N  = swlap_pkg::NUM_CELLS;
  localparam int SW = swlap_pkg::SEG_W;

  logic                running_r, running_nxt;
  logic                out_valid_r;
  swlap_pkg::out_req_t out_data_r, out_data_nxt;
  logic                accept;
  swlap_pkg::cell_ctl_t ctl;

  logic [N:0]          carry;
  swlap_pkg::digit_t   shown [N];

  // Hold input while a finished request waits at a stalled output.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Stop wins over start; the increment uses the updated running flag.
  always_comb begin
    running_nxt = running_r;
    if (in_data.start_press) begin
      running_nxt = 1'b1;
    end
    if (in_data.stop_press) begin
      running_nxt = 1'b0;
    end
  end

  assign ctl.adv   = accept;
  assign ctl.lap   = in_data.lap_press;
  assign ctl.clear = in_data.clear_press;
  assign ctl.show  = in_data.show_lap;
  assign carry[0]  = running_nxt;

  // Row of digit cells: hundredths at position 0, minutes tens at the end.
  for (genvar i = 0; i < N; i++) begin : g_cell
    swlap_digit_cell #(
      .MODULUS(swlap_pkg::cell_modulus(i))
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .carry_in  (carry[i]),
      .carry_out (carry[i+1]),
      .shown     (shown[i])
    );
  end

  // Encode the displayed digits; carry[N] marks the wrap at one hundred minutes
  // and needs no action since every cell already returns to zero.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      out_data_nxt.low_digit_segments[i*SW +: SW] = swlap_pkg::seg_of(shown[i]);
    end
    for (int i = 0; i < 2; i++) begin
      out_data_nxt.high_digit_segments[i*SW +: SW] = swlap_pkg::seg_of(shown[i+4]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        running_r <= running_nxt;
      end
      // Load on accept, drop once taken, otherwise hold.
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: src/swlap_checker.sv
module swlap_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input swlap_pkg::out_req_t out_data
);

  // A stalled output request stays and holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output request changed");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Every accepted request yields a result on the next cycle.
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted request produced no result");

  // Seconds tens never shows a digit above five.
  a_sec_tens: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.low_digit_segments[31:24] != 8'h7D &&
                  out_data.low_digit_segments[31:24] != 8'h07 &&
                  out_data.low_digit_segments[31:24] != 8'h7F &&
                  out_data.low_digit_segments[31:24] != 8'h6F)
    else $error("seconds tens out of range");

  // Input is held off only while a result waits at a stalled output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

endmodule

bind stopwatch_lap_seven_segment_unit swlap_checker u_swlap_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
